// File: rtl/bdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdl_pkg
// shared constants and types of the box downsampler
// ----------------------------------------------------------------------------
package bdl_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_COMPONENTS = 4;
  localparam int SAMPLE_BITS    = 16;

  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 16;
  localparam int MAX_LEVEL  = 5;

  localparam int OUT_COMPS = 4;
  localparam int COMP_W    = 16;
  localparam int POS_W     = 12;
  localparam int LOD_W     = 3;
  localparam int CNT_W     = 3;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = 28;

  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int WD_W      = X_W + 1;
  localparam int Y_W       = $clog2(MAX_HEIGHT);
  localparam int HD_W      = Y_W + 1;
  localparam int COL_DEPTH = MAX_WIDTH / 2;
  localparam int COL_AW    = $clog2(COL_DEPTH);
  localparam int LANE_W    = MAX_COMPONENTS * SUM_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int IN_TDATA_W  = OUT_COMPS * COMP_W;
  localparam int OUT_BITS    = OUT_COMPS * COMP_W + 2 * POS_W + LOD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_REQ_LOD       = 3'd2,
    REG_COMP_COUNT    = 3'd3,
    REG_SAMPLE_SIGNED = 3'd4
  } cfg_reg_t;

  typedef logic [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic              upd;
    logic              first_col;
    logic              wr;
    logic              first_row;
    logic              emit;
    logic              last;
    logic [COL_AW-1:0] addr;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [LOD_W-1:0]  lod;
  } pix_ctl_t;

  typedef struct packed {
    logic                       last;
    logic [LOD_W-1:0]           lod;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    comp_t [OUT_COMPS-1:0]      comp;
  } out_item_t;

endpackage

// File: rtl/box_downsample_lod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_lod
// power-of-two box filter downsampler for a raster pixel stream
// ----------------------------------------------------------------------------
// Takes one source pixel per clock, back to back while the result queue has
// room, and returns each averaged pixel through the stage-one register and a
// four-entry result queue. The rate is set by the column sum memory (2048
// entries of four 28-bit sums), which takes one read and one write per cycle:
// the read is issued when a pixel ends a horizontal block run and the updated
// sums are written back the next cycle. That memory needs no clearing after
// reset, since the first row of every block overwrites its entry. A
// configuration write to indices 0 to 4 restarts the frame at column 0, row 0.
module box_downsample_lod
  import bdl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // comp_a, comp_b, comp_c, comp_d
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_comp_a..d, out_column, out_row, effective_lod
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  function automatic logic [WD_W-1:0] eff_width(input logic [CFG_W-1:0] raw);
    logic [WD_W-1:0] w;
    if (raw == '0) begin
      w = WD_W'(1);
    end else if (32'(raw) > MAX_WIDTH) begin
      w = WD_W'(MAX_WIDTH);
    end else begin
      w = WD_W'(raw);
    end
    return w;
  endfunction

  function automatic logic [HD_W-1:0] eff_height(input logic [CFG_W-1:0] raw);
    logic [HD_W-1:0] h;
    if (raw == '0) begin
      h = HD_W'(1);
    end else if (32'(raw) > MAX_HEIGHT) begin
      h = HD_W'(MAX_HEIGHT);
    end else begin
      h = HD_W'(raw);
    end
    return h;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] n;
    if (raw == '0) begin
      n = CNT_W'(1);
    end else if (32'(raw) > MAX_COMPONENTS) begin
      n = CNT_W'(MAX_COMPONENTS);
    end else begin
      n = raw;
    end
    return n;
  endfunction

  function automatic logic [LOD_W-1:0] calc_lod(input logic [WD_W-1:0]  w,
                                                 input logic [HD_W-1:0]  h,
                                                 input logic [LOD_W-1:0] req);
    logic [LOD_W-1:0] l;
    l = (32'(req) > MAX_LEVEL) ? LOD_W'(MAX_LEVEL) : req;
    for (int i = 0; i < MAX_LEVEL; i++) begin
      if (l != '0 && (((w >> l) < WD_W'(MIN_SIZE)) || ((h >> l) < HD_W'(MIN_SIZE)))) begin
        l = l - 1'b1;
      end
    end
    return l;
  endfunction

  // configuration
  logic [CFG_W-1:0] wid_raw_r, wid_raw_nxt;
  logic [CFG_W-1:0] hgt_raw_r, hgt_raw_nxt;
  logic [LOD_W-1:0] lod_raw_r, lod_raw_nxt;
  logic [CNT_W-1:0] cnt_raw_r, cnt_raw_nxt;
  logic             sgn_r, sgn_nxt;
  logic [WD_W-1:0]  w_r;
  logic [HD_W-1:0]  h_r;
  logic [CNT_W-1:0] cnt_r;
  logic [LOD_W-1:0] lvl_r;
  logic             restart;

  // position
  logic [X_W-1:0]   x_r;
  logic [Y_W-1:0]   y_r;
  logic             x_end, y_end;

  // pixel control
  logic [MAX_LEVEL-1:0] blk_mask;
  logic [MAX_LEVEL-1:0] kx, ky;
  logic [X_W-1:0]       bx;
  logic [Y_W-1:0]       by;
  logic [WD_W-1:0]      dw;
  logic [HD_W-1:0]      dh;
  logic                 in_blk;
  logic                 lvl0;
  pix_ctl_t             ctl;

  logic                 in_fire;
  logic                 s1_busy;
  logic                 res_valid;
  out_item_t            res_item;
  out_item_t            q_item;
  logic [FIFO_AW:0]     q_cnt;
  logic [FIFO_AW+1:0]   q_need;

  always_comb begin
    wid_raw_nxt = wid_raw_r;
    hgt_raw_nxt = hgt_raw_r;
    lod_raw_nxt = lod_raw_r;
    cnt_raw_nxt = cnt_raw_r;
    sgn_nxt     = sgn_r;
    restart     = cfg_we;
    case (cfg_reg_t'(cfg_index))
      REG_SRC_WIDTH:     wid_raw_nxt = cfg_data;
      REG_SRC_HEIGHT:    hgt_raw_nxt = cfg_data;
      REG_REQ_LOD:       lod_raw_nxt = cfg_data[LOD_W-1:0];
      REG_COMP_COUNT:    cnt_raw_nxt = cfg_data[CNT_W-1:0];
      REG_SAMPLE_SIGNED: sgn_nxt     = cfg_data[0];
      default:           restart     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_raw_r <= CFG_W'(256);
      hgt_raw_r <= CFG_W'(256);
      lod_raw_r <= '0;
      cnt_raw_r <= CNT_W'(4);
      sgn_r     <= 1'b0;
      w_r       <= eff_width(CFG_W'(256));
      h_r       <= eff_height(CFG_W'(256));
      cnt_r     <= eff_count(CNT_W'(4));
      lvl_r     <= '0;
    end else if (restart) begin
      wid_raw_r <= wid_raw_nxt;
      hgt_raw_r <= hgt_raw_nxt;
      lod_raw_r <= lod_raw_nxt;
      cnt_raw_r <= cnt_raw_nxt;
      sgn_r     <= sgn_nxt;
      w_r       <= eff_width(wid_raw_nxt);
      h_r       <= eff_height(hgt_raw_nxt);
      cnt_r     <= eff_count(cnt_raw_nxt);
      lvl_r     <= calc_lod(eff_width(wid_raw_nxt), eff_height(hgt_raw_nxt), lod_raw_nxt);
    end
  end

  assign in_fire = in_tvalid && in_tready;
  assign x_end   = ({1'b0, x_r} == w_r - 1'b1);
  assign y_end   = ({1'b0, y_r} == h_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      x_r <= '0;
      y_r <= '0;
    end else if (in_fire) begin
      if (x_end) begin
        x_r <= '0;
        y_r <= y_end ? '0 : y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // block geometry of the current pixel
  always_comb begin
    blk_mask = MAX_LEVEL'((32'd1 << lvl_r) - 32'd1);
    kx       = x_r[MAX_LEVEL-1:0] & blk_mask;
    ky       = y_r[MAX_LEVEL-1:0] & blk_mask;
    bx       = x_r >> lvl_r;
    by       = y_r >> lvl_r;
    dw       = w_r >> lvl_r;
    dh       = h_r >> lvl_r;
    in_blk   = ({1'b0, bx} < dw) && ({1'b0, by} < dh);
    lvl0     = (lvl_r == '0);

    ctl           = '0;
    ctl.lod       = lvl_r;
    ctl.addr      = bx[COL_AW-1:0];
    ctl.first_col = (kx == '0);
    ctl.first_row = (ky == '0);
    if (lvl0) begin
      ctl.emit = 1'b1;
      ctl.col  = POS_W'(x_r);
      ctl.row  = POS_W'(y_r);
      ctl.last = x_end && y_end;
    end else begin
      ctl.upd  = in_blk;
      ctl.wr   = in_blk && (kx == blk_mask);
      ctl.emit = in_blk && (kx == blk_mask) && (ky == blk_mask);
      ctl.col  = POS_W'(bx);
      ctl.row  = POS_W'(by);
      ctl.last = ({1'b0, bx} == dw - 1'b1) && ({1'b0, by} == dh - 1'b1);
    end
  end

  bdl_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .in_fire      (in_fire),
    .ctl          (ctl),
    .samples      (in_tdata),
    .sample_signed(sgn_r),
    .comp_cnt     (cnt_r),
    .s1_busy      (s1_busy),
    .res_valid    (res_valid),
    .res_item     (res_item)
  );

  bdl_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_item(res_item),
    .pop      (out_tvalid && out_tready),
    .out_valid(out_tvalid),
    .out_item (q_item),
    .count    (q_cnt)
  );

  // room for the pixel in flight plus this one
  assign q_need    = {1'b0, q_cnt} + (FIFO_AW+2)'(s1_busy);
  assign in_tready = (q_need < (FIFO_AW+2)'(FIFO_DEPTH));

  assign out_tdata = OUT_TDATA_W'({q_item.lod, q_item.row, q_item.col, q_item.comp});
  assign out_tlast = q_item.last;

  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (x_r == '0 && y_r == '0))
    else $error("position not cleared by configuration write");

  a_emit_has_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !lvl0 && ctl.emit) |-> ctl.wr)
    else $error("block result without column sum update");

endmodule

// File: rtl/bdl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bdl_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdl_accum
// row partial sums, column sum memory read-modify-write and block average
// ----------------------------------------------------------------------------
module bdl_accum
  import bdl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   restart,
  input  logic                   in_fire,
  input  pix_ctl_t               ctl,
  input  comp_t [OUT_COMPS-1:0]  samples,
  input  logic                   sample_signed,
  input  logic [CNT_W-1:0]       comp_cnt,
  output logic                   s1_busy,
  output logic                   res_valid,
  output out_item_t              res_item
);

  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] samp_ext;
  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] part_r;
  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] part_nxt;
  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] s1_part_r;
  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] col_old;
  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] col_sum;
  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] avg;
  logic                                 s1_v_r;
  pix_ctl_t                             s1_ctl_r;
  logic [LANE_W-1:0]                    ram_rdata;
  logic                                 ram_we;
  logic                                 ram_re;
  logic [3:0]                           avg_sh;

  always_comb begin
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      samp_ext[c] = {{(SUM_W-SAMPLE_BITS){sample_signed & samples[c][SAMPLE_BITS-1]}},
                     samples[c][SAMPLE_BITS-1:0]};
      part_nxt[c] = ctl.first_col ? samp_ext[c] : part_r[c] + samp_ext[c];
    end
  end

  // horizontal partial sums
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      part_r <= '0;
    end else if (in_fire && ctl.upd) begin
      part_r <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r  <= ctl;
      s1_part_r <= ctl.upd ? part_nxt : samp_ext;
    end
  end

  assign ram_re = in_fire && ctl.wr;
  assign ram_we = s1_v_r && s1_ctl_r.wr;

  bdl_ram #(
    .WIDTH(LANE_W),
    .DEPTH(COL_DEPTH)
  ) u_col_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_ctl_r.addr),
    .wdata(col_sum),
    .re   (ram_re),
    .raddr(ctl.addr),
    .rdata(ram_rdata)
  );

  assign col_old = ram_rdata;
  assign avg_sh  = {s1_ctl_r.lod, 1'b0};

  // vertical sum and average, truncating toward zero
  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] qmag;
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      col_sum[c] = (s1_ctl_r.first_row || !s1_ctl_r.wr) ? s1_part_r[c]
                                                         : col_old[c] + s1_part_r[c];
      mag        = col_sum[c][SUM_W-1] ? -col_sum[c] : col_sum[c];
      qmag       = mag >> avg_sh;
      avg[c]     = col_sum[c][SUM_W-1] ? -qmag : qmag;
    end
  end

  always_comb begin
    res_item      = '0;
    res_item.last = s1_ctl_r.last;
    res_item.lod  = s1_ctl_r.lod;
    res_item.row  = s1_ctl_r.row;
    res_item.col  = s1_ctl_r.col;
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      if (CNT_W'(c) < comp_cnt) begin
        res_item.comp[c] = COMP_W'(avg[c][SAMPLE_BITS-1:0]);
      end
    end
  end

  assign res_valid = s1_v_r && s1_ctl_r.emit;
  assign s1_busy   = s1_v_r;

  // consecutive block updates never hit the same column entry
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (s1_ctl_r.addr != ctl.addr))
    else $error("column sum read overlaps pending write");

endmodule

// File: rtl/bdl_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdl_ofifo
// small result queue in front of the output channel
// ----------------------------------------------------------------------------
module bdl_ofifo
  import bdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  out_item_t          push_item,
  input  logic               pop,
  output logic               out_valid,
  output out_item_t          out_item,
  output logic [FIFO_AW:0]   count
);

  out_item_t          ents_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ents_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_item  = ents_r[rd_ptr_r];
  assign count     = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r < (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("result queue underflow");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the power-of-two box filter downsampler
// ----------------------------------------------------------------------------
// Streams raster pixels into the block under several frame geometries, levels,
// component counts and sample encodings. A scoreboard keeps its own copy of the
// block sum and position state, predicts every averaged pixel, and compares
// each returned transaction field by field. Both stream sides insert random
// gaps, with some phases run back to back. Settings change only while the
// block is drained.
// ----------------------------------------------------------------------------
module tb_top
  import bdl_pkg::*;
();

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 200;
  localparam int ITEM_TARGET   = 1800;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_MIN, FILL_MAX, FILL_EXTREME} fill_t;

  class box_avg_scoreboard;
    int mismatches;
    out_item_t expected_q[$];

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [2:0]       lod_reg;
    logic [2:0]       count_reg;
    logic             sign_reg;

    int col_sum[COL_DEPTH * MAX_COMPONENTS];
    int row_part[MAX_COMPONENTS];
    int pos_x;
    int pos_y;
    int level;

    function new();
      mismatches   = 0;
      width_reg    = CFG_W'(256);
      height_reg   = CFG_W'(256);
      lod_reg      = 3'd0;
      count_reg    = 3'd4;
      sign_reg     = 1'b0;
      restart_frame();
    endfunction

    function int frame_width();
      int w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int frame_height();
      int h;
      h = height_reg;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function void restart_frame();
      int w;
      int h;
      int l;
      w = frame_width();
      h = frame_height();
      l = (lod_reg > MAX_LEVEL) ? MAX_LEVEL : lod_reg;
      while (l > 0 && ((w >> l) < MIN_SIZE || (h >> l) < MIN_SIZE)) l--;
      level = l;
      pos_x = 0;
      pos_y = 0;
      foreach (row_part[c]) row_part[c] = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SRC_WIDTH:     width_reg  = val;
        REG_SRC_HEIGHT:    height_reg = val;
        REG_REQ_LOD:       lod_reg    = val[2:0];
        REG_COMP_COUNT:    count_reg  = val[2:0];
        REG_SAMPLE_SIGNED: sign_reg   = val[0];
        default: return;
      endcase
      restart_frame();
    endfunction

    // sum / (n*n), truncated toward zero
    function comp_t box_mean(int total);
      int q;
      if (total < 0) q = -((-total) >> (2 * level));
      else q = total >> (2 * level);
      return q[COMP_W-1:0];
    endfunction

    function void note_pixel(logic [IN_TDATA_W-1:0] pix);
      int w;
      int h;
      int cnt;
      int n;
      int dw;
      int dh;
      int bx;
      int by;
      int kx;
      int ky;
      int v;
      int idx;
      comp_t raw;
      out_item_t item;
      w    = frame_width();
      h    = frame_height();
      cnt  = (count_reg == 0) ? 1 : ((count_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : count_reg);
      item = '0;
      if (level == 0) begin
        for (int c = 0; c < cnt; c++) item.comp[c] = pix[c*COMP_W +: COMP_W];
        item.col  = POS_W'(pos_x);
        item.row  = POS_W'(pos_y);
        item.last = (pos_x == w - 1 && pos_y == h - 1);
        expected_q.push_back(item);
      end else begin
        n  = 1 << level;
        dw = w >> level;
        dh = h >> level;
        bx = pos_x >> level;
        by = pos_y >> level;
        kx = pos_x & (n - 1);
        ky = pos_y & (n - 1);
        if (bx < dw && by < dh) begin
          for (int c = 0; c < cnt; c++) begin
            raw = pix[c*COMP_W +: COMP_W];
            v   = sign_reg ? int'($signed(raw)) : int'(raw);
            row_part[c] = (kx == 0) ? v : row_part[c] + v;
          end
          if (kx == n - 1) begin
            for (int c = 0; c < cnt; c++) begin
              idx = bx * MAX_COMPONENTS + c;
              col_sum[idx] = (ky == 0) ? row_part[c] : col_sum[idx] + row_part[c];
              if (ky == n - 1) item.comp[c] = box_mean(col_sum[idx]);
            end
            if (ky == n - 1) begin
              item.col  = POS_W'(bx);
              item.row  = POS_W'(by);
              item.lod  = LOD_W'(level);
              item.last = (bx == dw - 1 && by == dh - 1);
              expected_q.push_back(item);
            end
          end
        end
      end
      pos_x++;
      if (pos_x >= w) begin
        pos_x = 0;
        pos_y++;
        if (pos_y >= h) pos_y = 0;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last_flag);
      out_item_t got;
      out_item_t want;
      got = {last_flag, data[OUT_BITS-1:0]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel expected none actual %0h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_comp_a", want.comp[0], got.comp[0]);
      compare_field("out_comp_b", want.comp[1], got.comp[1]);
      compare_field("out_comp_c", want.comp[2], got.comp[2]);
      compare_field("out_comp_d", want.comp[3], got.comp[3]);
      compare_field("out_column", want.col, got.col);
      compare_field("out_row", want.row, got.row);
      compare_field("effective_lod", want.lod, got.lod);
      compare_field("last_of_frame", want.last, got.last);
      compare_field("tdata padding", 0, data[OUT_TDATA_W-1:OUT_BITS]);
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;

  bit steady = 1'b0;
  int cycle_count = 0;
  int pixels_sent = 0;
  box_avg_scoreboard sb = new();

  box_downsample_lod dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] make_pixel(fill_t fill);
    logic [IN_TDATA_W-1:0] pix;
    comp_t val;
    for (int c = 0; c < OUT_COMPS; c++) begin
      case (fill)
        FILL_ONES: val = 16'hffff;
        FILL_MIN:  val = 16'h8000;
        FILL_MAX:  val = 16'h7fff;
        FILL_EXTREME: begin
          case ($urandom_range(0, 3))
            0: val = 16'h0000;
            1: val = 16'hffff;
            2: val = 16'h8000;
            default: val = 16'h7fff;
          endcase
        end
        default: val = COMP_W'($urandom);
      endcase
      pix[c*COMP_W +: COMP_W] = val;
    end
    return pix;
  endfunction

  task automatic send_pixel(input logic [IN_TDATA_W-1:0] pix);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix);
    pixels_sent++;
  endtask

  task automatic run_pixels(input int npix, input fill_t fill);
    for (int i = 0; i < npix; i++) send_pixel(make_pixel(fill));
  endtask

  // stop feeding and let every pending block sum and result leave the block
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic run_phase(input int w, input int h, input int lod, input int cnt,
                           input int sgn, input int npix, input fill_t fill,
                           input bit stdy);
    drain_block();
    write_reg(REG_SRC_WIDTH, CFG_W'(w));
    write_reg(REG_SRC_HEIGHT, CFG_W'(h));
    write_reg(REG_REQ_LOD, CFG_W'(lod));
    write_reg(REG_COMP_COUNT, CFG_W'(cnt));
    write_reg(REG_SAMPLE_SIGNED, CFG_W'(sgn));
    cfg_we <= 1'b0;
    steady = stdy;
    run_pixels(npix, fill);
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tlast);
    end
  end

  initial begin : stimulus
    int w;
    int h;
    int npix;
    fill_t fill;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, pass-through
    run_pixels(2, FILL_ONES);
    run_pixels(2, FILL_MIN);
    run_pixels(2, FILL_MAX);
    run_pixels(6, FILL_EXTREME);

    // zero count, level forced down by a narrow frame
    run_phase(20, 3, 3, 0, 1, 4, FILL_ONES, 1'b0);
    // saturated width, zero height, count above range
    run_phase(8191, 0, 0, 7, 1, 16, FILL_RANDOM, 1'b0);
    // one pixel wide, full height, level 7 clamped then dropped
    run_phase(0, 4096, 7, 2, 0, 16, FILL_RANDOM, 1'b1);
    // signed level 1 with dropped edge column and row, full frame and a bit of the next
    run_phase(33, 33, 1, 4, 1, 1109, FILL_EXTREME, 1'b0);
    // level 6 clamped to 5, lowered to 2, first block row
    run_phase(64, 64, 6, 4, 1, 256, FILL_RANDOM, 1'b1);
    // level 5 requested, lowered to 1 by the height
    run_phase(64, 40, 5, 1, 0, 128, FILL_ONES, 1'b0);

    while (pixels_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 12);
      end else begin
        w = $urandom_range(32, 100);
        h = $urandom_range(32, 72);
      end
      if (w * h <= 400) npix = w * h + $urandom_range(0, w * h);
      else npix = $urandom_range(100, 250);
      if ($urandom_range(0, 1)) fill = FILL_RANDOM;
      else fill = fill_t'($urandom_range(0, 4));
      run_phase(w, h, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1),
                npix, fill, $urandom_range(0, 3) == 0);
    end

    drain_block();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
